/* rtl/signed_int_to_decimal_ascii_assert.svh */
// Assertion macros shared by the signed integer to decimal ASCII block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sida: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sida: next-cycle check failed");

`endif

/* rtl/sida_pkg.sv */
// Shared types and constants of the signed integer to decimal ASCII block.
package sida_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    typedef logic [3:0] t_digit;

    // Controls broadcast to every digit cell of the chain.
    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctl;

endpackage

/* rtl/sida_if.sv */
// Stream interfaces for the integer input and the character output of the block.
interface sida_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sida_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

/* rtl/sida_cell.sv */
// One BCD digit cell: shift-and-add-3 step during conversion, plain shift during output.
module sida_cell
    import sida_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_bit,
    input  t_digit    i_digit,
    output logic      o_carry,
    output t_digit    o_digit
);

    t_digit r_digit;
    t_digit w_adj;

    // Correct the digit before the doubling so that it stays decimal.
    assign w_adj   = (r_digit > 4'd4) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.conv) begin
            r_digit <= {w_adj[2:0], i_bit};
        end else if (i_ctl.shift) begin
            r_digit <= i_digit;
        end
    end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII text, one character per output transaction.
// Order: the input transaction, the bit-serial conversion steps through the digit chain, then a
// minus sign for a negative value, then the digits once leading zeros (up to NDIG - 1) are skipped.
// A new integer is taken only after the last character of the previous one has been registered;
// an output register that is still full stalls the emission of the characters.
// Reset (synchronous, active low) returns the controller to idle and empties the output register.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sida_in_if.sink      i_in,
    sida_out_if.source   o_out
);

    `include "signed_int_to_decimal_ascii_assert.svh"

    // Number of decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
    // log10(2) is approximated by 30103/100000, exact enough over the supported range.
    localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W = $clog2(NDIG + 1);

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_sign, n_sign;
    logic                  r_started, n_started;
    logic                  r_ovalid, n_ovalid;
    logic [6:0]            r_char, n_char;
    logic                  r_last, n_last;

    logic [VALUE_BITS-1:0] w_value;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_abs;
    logic                  w_out_free;
    t_cell_ctl             w_ctl;
    t_digit                w_digit [NDIG];
    logic                  w_carry [NDIG];
    t_digit                w_top;
    logic                  w_char_is_digit;
    logic                  w_run_end;

    assign w_value    = i_in.value;
    assign w_neg      = w_value[VALUE_BITS-1];
    // The magnitude is taken at full width, so the most negative value maps to 2^(VALUE_BITS-1).
    assign w_abs      = w_neg ? (~w_value + 1'b1) : w_value;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_top      = w_digit[NDIG-1];

    // The digit chain. Cell 0 holds the least significant digit. During conversion the
    // magnitude enters cell 0 most significant bit first, and each cell passes the bit it
    // doubles out of its top to the next cell up. During output the digits move up one
    // cell per step, so the most significant digit is always read from the top cell.
    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        logic   w_bit_in;
        t_digit w_digit_in;

        if (k == 0) begin : g_first
            assign w_bit_in   = r_mag[VALUE_BITS-1];
            assign w_digit_in = '0;
        end else begin : g_next
            assign w_bit_in   = w_carry[k-1];
            assign w_digit_in = w_digit[k-1];
        end

        sida_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit_in),
            .i_digit (w_digit_in),
            .o_carry (w_carry[k]),
            .o_digit (w_digit[k])
        );
    end

    // Sequencing: accept one integer, run VALUE_BITS conversion steps through the chain,
    // then emit the optional minus sign followed by the digits. Leading zeros are shifted
    // out of the top cell without producing a transaction, except for the units digit,
    // which is always sent so that zero gives a single '0'.
    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_sign    = r_sign;
        n_started = r_started;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_char    = r_char;
        n_last    = r_last;
        w_ctl     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    w_ctl.clear = 1'b1;
                    n_mag       = w_abs;
                    n_sign      = w_neg;
                    n_cnt       = CNT_W'(VALUE_BITS - 1);
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.conv = 1'b1;
                n_mag      = {r_mag[VALUE_BITS-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_left    = LEFT_W'(NDIG);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_sign) begin
                        n_ovalid = 1'b1;
                        n_char   = CHAR_MINUS;
                        n_last   = 1'b0;
                        n_sign   = 1'b0;
                    end else if (w_top == '0 && !r_started && r_left != LEFT_W'(1)) begin
                        w_ctl.shift = 1'b1;
                        n_left      = r_left - 1'b1;
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_left      = r_left - 1'b1;
                        n_started   = 1'b1;
                        n_ovalid    = 1'b1;
                        n_char      = CHAR_ZERO + {3'b000, w_top};
                        n_last      = (r_left == LEFT_W'(1));
                        if (r_left == LEFT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sign    <= 1'b0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sign    <= n_sign;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload and counters; their contents only matter once the controller has loaded them.
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    // Helpers for the checks below.
    assign w_char_is_digit = (o_out.character >= CHAR_ZERO) &&
                             (o_out.character <= (CHAR_ZERO + {3'b000, DIGIT_MAX}));
    assign w_run_end       = (r_state == S_EMIT) && (n_state == S_IDLE);

    // A magnitude of VALUE_BITS bits always fits in NDIG digits, so nothing leaves the top cell.
    `SIDA_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, r_state == S_CONV, !w_carry[NDIG-1])
    // Every digit read out of the top of the chain is a proper decimal digit.
    `SIDA_ASSERT_NOW(a_top_decimal, i_clk, i_rst_n, r_state == S_EMIT, w_top <= DIGIT_MAX)
    // The marked final character is always a digit, never the minus sign.
    `SIDA_ASSERT_NOW(a_last_digit, i_clk, i_rst_n, o_out.valid && o_out.last, w_char_is_digit)
    // Finishing a run always leaves a marked final character in the output register.
    `SIDA_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, w_run_end, o_out.valid && o_out.last && !r_sign)

endmodule

/* sim/sida_checker.sv */
// Checker for the integer-to-text block: predicts each character run and compares the output.
`timescale 1ns / 1ps

module sida_checker
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_in_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [6:0]                   i_out_character,
    input  logic                         i_out_last,
    input  logic                         i_run_done,
    output int                           o_pending,
    output int                           o_fail_count,
    output int                           o_chars_checked
);

    // Enough decimal digits for the widest value the block supports.
    localparam int DIGIT_SLOTS = 20;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_text_char;

    t_text_char expected_text [$];
    int         fail_count    = 0;
    int         chars_checked = 0;
    logic       end_checked   = 1'b0;

    assign o_fail_count    = fail_count;
    assign o_chars_checked = chars_checked;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Appends the decimal text of one integer to the queue of characters still to come.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digit_buf [0:DIGIT_SLOTS-1];
        int                    n_digits;
        logic                  negative;
        t_text_char            text_char;
        negative  = value[VALUE_BITS-1];
        magnitude = negative ? (~value + 1'b1) : value;
        n_digits  = 0;
        do begin
            digit_buf[n_digits] = 4'(magnitude % 10);
            magnitude           = magnitude / 10;
            n_digits++;
        end while (magnitude != 0 && n_digits < DIGIT_SLOTS);
        if (negative) begin
            text_char.character = CHAR_MINUS;
            text_char.last      = 1'b0;
            expected_text.push_back(text_char);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            text_char.character = CHAR_ZERO + 7'(digit_buf[i]);
            text_char.last      = (i == 0);
            expected_text.push_back(text_char);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char oldest;
        if (i_rst_n) begin
            // A character can never belong to an integer taken at the same edge,
            // so the output side is checked before the new prediction is queued.
            if (i_out_valid && i_out_ready) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              i_out_character, i_out_last));
                end else begin
                    oldest = expected_text.pop_front();
                    if (i_out_character !== oldest.character)
                        report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                                  i_out_character, oldest.character));
                    if (i_out_last !== oldest.last)
                        report_mismatch($sformatf("last %0b, expected %0b (character 0x%02h)",
                                                  i_out_last, oldest.last, oldest.character));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_text(i_in_value);
            if (i_run_done && !end_checked) begin
                end_checked = 1'b1;
                if (expected_text.size() != 0)
                    report_mismatch($sformatf("%0d characters never arrived",
                                              expected_text.size()));
            end
        end
        o_pending <= expected_text.size();
    end

endmodule

/* sim/signed_int_to_decimal_ascii_test.sv */
// Top of the testbench: clock, reset, integer stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;
    import sida_pkg::*;

    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int RESET_CYCLES = 7;
    // Random integers after the directed ones; together they come to 330.
    localparam int RANDOM_ITEMS = 310;
    // Index within the random part at which the receiver starts its long hold-off.
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 200;
    // Index within the random part from which neither side idles any more.
    localparam int CALM_FROM    = 250;
    // Tail after the output drains, so that any straggler would still be seen.
    localparam int DRAIN_CYCLES = 60;
    // Cycles without a single transaction before the run is declared hung.
    localparam int IDLE_LIMIT   = 2000;

    // Extremes, digit-count boundaries and bit patterns: every digit, both signs,
    // zero and the most negative value all appear here.
    localparam logic [31:0] DIRECTED_VALUES [20] = '{
        32'd0,              32'd1,              -32'sd1,            32'd9,
        32'd10,             -32'sd10,           32'd99,             -32'sd100,
        32'h7FFF_FFFF,      32'h8000_0000,      32'h8000_0001,      32'd1000000000,
        -32'sd1000000000,   32'd999999999,      -32'sd999999999,    32'd1234567890,
        -32'sd1234567890,   -32'sd9,            32'h5555_5555,      32'hAAAA_AAAA
    };

    logic clk;
    logic rst_n;

    // Flags shared between the sender and the receiver.
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;
    logic calm         = 1'b0;
    logic run_done;

    int   pending;
    int   fail_count;
    int   chars_checked;
    int   values_sent    = 0;
    int   negatives_sent = 0;

    sida_in_if #(.VALUE_BITS(VALUE_BITS)) int_ch ();
    sida_out_if                           char_ch ();

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (int_ch),
        .o_out   (char_ch)
    );

    sida_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (int_ch.valid),
        .i_in_ready      (int_ch.ready),
        .i_in_value      (int_ch.value),
        .i_out_valid     (char_ch.valid),
        .i_out_ready     (char_ch.ready),
        .i_out_character (char_ch.character),
        .i_out_last      (char_ch.last),
        .i_run_done      (run_done),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_chars_checked (chars_checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Picks a random integer. Four draws in ten are fully random words, so every bit
    // takes both values; the rest aim at short runs, at the edges where the
    // digit count changes, and at the neighbourhood of the two extremes.
    function automatic logic [31:0] pick_value();
        logic [31:0] word;
        int unsigned decade;
        int          kind;
        kind   = $urandom_range(0, 9);
        decade = 1;
        case (kind)
            0, 1, 2, 3: begin
                word = $urandom;
            end
            4, 5: begin
                word = $urandom_range(0, 999);
            end
            6, 7: begin
                repeat ($urandom_range(0, 9)) decade *= 10;
                word = decade + $urandom_range(0, 2) - 1;
            end
            8: begin
                if ($urandom_range(0, 1) == 1)
                    word = 32'h8000_0000 + $urandom_range(0, 3);
                else
                    word = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            default: begin
                word = $urandom >> $urandom_range(0, 31);
            end
        endcase
        // The sign is left alone for the extremes and the fully random words, which already cover both.
        if (kind != 8 && kind < 4 == 0 && $urandom_range(0, 1) == 1)
            word = -word;
        return word;
    endfunction

    // Offers one integer and holds it until the block accepts the transaction.
    // Valid is left high so that a back-to-back transaction can follow at once.
    task automatic send_value(input logic [31:0] value);
        int_ch.valid <= 1'b1;
        int_ch.value <= value;
        @(posedge clk);
        while (!int_ch.ready) @(posedge clk);
        values_sent++;
        if (value[31]) negatives_sent++;
    endtask

    // Occasionally drops valid for a short burst before the next transaction,
    // except while the receiver's long hold-off is under way or the run has
    // entered its calm final stretch.
    task automatic maybe_idle();
        if (!calm && !(hold_request && !hold_done) && $urandom_range(0, 4) == 0) begin
            int_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Withdraws valid and waits until every predicted character has come out.
    task automatic wait_until_empty();
        int_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: mostly ready, with short random stalls, one long hold-off when
    // the sender asks for it, and no stalls at all in the calm final stretch.
    initial begin
        char_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request && !hold_done) begin
                char_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                char_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                char_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: the run is hung if no transaction happens on either channel
    // before the idle counter reaches IDLE_LIMIT.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((int_ch.valid && int_ch.ready) || (char_ch.valid && char_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus and verdict.
    initial begin
        rst_n        <= 1'b0;
        run_done     <= 1'b0;
        int_ch.valid <= 1'b0;
        int_ch.value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the usual random gaps.
        foreach (DIRECTED_VALUES[i]) begin
            maybe_idle();
            send_value(DIRECTED_VALUES[i]);
        end
        // First pause: the sender waits for the block to empty completely.
        wait_until_empty();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) begin
                // The receiver stalls for a long stretch while transactions keep
                // being offered back to back, so the block backs up to its input.
                hold_request = 1'b1;
            end
            if (n == HOLD_AT + 40) begin
                // Second pause, once the hold-off has been released.
                wait_until_empty();
            end
            if (n == CALM_FROM)
                calm = 1'b1;
            maybe_idle();
            send_value(pick_value());
        end

        // Drain: wait for every character, then a tail for any stray output.
        int_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Converted %0d integers (%0d negative) into %0d checked characters.",
                 values_sent, negatives_sent, chars_checked);
        $display("Included a %0d-cycle output stall and two waits for an empty block.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
